FILE: hw/rtl/ows_pkg.sv
// Shared types, codes and helpers for the obstacle wait sequencer.
// Used by ows_core, ows_outq and obstacle_wait_sequencer; no dependencies.
package ows_pkg;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_SEEN_FRAMES  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOST_FRAMES  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DETECT_TO    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WAIT_TO      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_COMMAND_TO   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_RAISE_IDS    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_LOWER_IDS    = 3'd6;

    localparam logic [1:0] MODE_START    = 2'd0;
    localparam logic [1:0] MODE_TICK     = 2'd1;
    localparam logic [1:0] MODE_RESPONSE = 2'd2;
    localparam logic [1:0] MODE_FEEDBACK = 2'd3;

    localparam logic [1:0] ST_RUNNING = 2'd0;
    localparam logic [1:0] ST_SUCCESS = 2'd1;
    localparam logic [1:0] ST_FAILURE = 2'd2;

    localparam logic [1:0] OC_RUNNING     = 2'd0;
    localparam logic [1:0] OC_NO_TARGET   = 2'd1;
    localparam logic [1:0] OC_TARGET_GONE = 2'd2;
    localparam logic [1:0] OC_FAILED      = 2'd3;

    localparam logic [2:0] ERR_NONE         = 3'd0;
    localparam logic [2:0] ERR_ACK_TIMEOUT  = 3'd1;
    localparam logic [2:0] ERR_REJECTED     = 3'd2;
    localparam logic [2:0] ERR_VISION_FAIL  = 3'd3;
    localparam logic [2:0] ERR_DONE_TIMEOUT = 3'd4;
    localparam logic [2:0] ERR_WAIT_TIMEOUT = 3'd5;

    localparam logic [2:0] PHN_DONE   = 3'd0;
    localparam logic [2:0] PHN_PREP   = 3'd1;
    localparam logic [2:0] PHN_DETECT = 3'd2;
    localparam logic [2:0] PHN_GONE   = 3'd3;

    localparam logic [23:0] TICK_MAX  = 24'hFF_FFFF;
    localparam logic [7:0]  COUNT_MAX = 8'hFF;

    typedef enum logic [3:0] {
        PH_DONE   = 4'b0001,
        PH_PREP   = 4'b0010,
        PH_DETECT = 4'b0100,
        PH_GONE   = 4'b1000
    } t_phase;

    typedef struct packed {
        logic [1:0]  mode;
        logic        go_down;
        logic        resp_accepted;
        logic [7:0]  msg_seq;
        logic [7:0]  feedback_code;
        logic        obs_valid;
        logic [31:0] obs_frame_seq;
        logic        obs_blocking;
        logic        sensor_ready;
        logic        vision_start_ok;
    } t_in;

    typedef struct packed {
        logic [1:0] node_status;
        logic [1:0] outcome;
        logic [2:0] error_code;
        logic       send_cmd;
        logic [7:0] cmd_code;
        logic [2:0] phase_now;
    } t_out;

    typedef struct packed {
        logic [7:0]  seen_frames;
        logic [7:0]  lost_frames;
        logic [23:0] detect_timeout_ticks;
        logic [23:0] wait_timeout_ticks;
        logic [23:0] command_timeout_ticks;
        logic [15:0] raise_ids;
        logic [15:0] lower_ids;
    } t_cfg;

    // bit 8 of the sequence fields is the valid bit
    typedef struct packed {
        t_phase      phase;
        logic        direction_down;
        logic [23:0] elapsed_ticks;
        logic [7:0]  seen_count;
        logic [7:0]  lost_count;
        logic [31:0] last_frame_seq;
        logic        ever_seen;
        logic        resp_seen;
        logic        accepted_flag;
        logic        done_seen;
        logic [8:0]  resp_seq;
        logic [8:0]  latest_done_seq;
    } t_state;

    localparam t_state STATE_RESET = '{phase: PH_DONE, default: '0};

    localparam t_cfg CFG_RESET = '{
        seen_frames:           8'd3,
        lost_frames:           8'd3,
        detect_timeout_ticks:  24'd100,
        wait_timeout_ticks:    24'd1000,
        command_timeout_ticks: 24'd200,
        raise_ids:             16'd0,
        lower_ids:             16'd0
    };

    function automatic logic [7:0] min_one8(input logic [7:0] v);
        return (v == 8'd0) ? 8'd1 : v;
    endfunction

    function automatic logic [23:0] min_one24(input logic [23:0] v);
        return (v == 24'd0) ? 24'd1 : v;
    endfunction

    function automatic logic [2:0] phase_code(input t_phase p);
        logic [2:0] c;
        unique case (p)
            PH_PREP:   c = PHN_PREP;
            PH_DETECT: c = PHN_DETECT;
            PH_GONE:   c = PHN_GONE;
            default:   c = PHN_DONE;
        endcase
        return c;
    endfunction

endpackage

FILE: hw/rtl/ows_core.sv
// Next-state and result logic for one item of the obstacle wait sequencer.
// Purely combinational; depends on ows_pkg.
module ows_core
    import ows_pkg::*;
(
    input  t_in    i_item,
    input  t_state i_state,
    input  t_cfg   i_cfg,
    output t_state o_state,
    output t_out   o_result
);

    logic [7:0]  sf;
    logic [7:0]  lf;
    logic [15:0] cur_ids;
    logic [15:0] start_ids;
    logic [8:0]  seq_tag;
    logic [23:0] el_inc;
    logic        late;
    logic        fresh;
    logic        blk;
    logic [8:0]  seen_inc;
    logic [7:0]  seen_sat;
    logic [7:0]  lost_inc;
    t_state      ns;
    t_out        res;

    assign sf        = min_one8(i_cfg.seen_frames);
    assign lf        = min_one8(i_cfg.lost_frames);
    assign cur_ids   = i_state.direction_down ? i_cfg.lower_ids : i_cfg.raise_ids;
    assign start_ids = i_item.go_down ? i_cfg.lower_ids : i_cfg.raise_ids;
    assign seq_tag   = {1'b1, i_item.msg_seq};
    assign el_inc    = (i_state.elapsed_ticks != TICK_MAX) ?
                       i_state.elapsed_ticks + 24'd1 : i_state.elapsed_ticks;
    assign late      = el_inc > min_one24(i_cfg.command_timeout_ticks);
    assign blk       = i_item.obs_blocking & i_item.obs_valid;
    assign fresh     = i_item.obs_valid && (i_item.obs_frame_seq != 32'd0) &&
                       (i_item.obs_frame_seq != i_state.last_frame_seq);
    assign seen_inc  = {1'b0, i_state.seen_count} + 9'd1;
    assign seen_sat  = (seen_inc < {1'b0, sf}) ? seen_inc[7:0] : sf;
    assign lost_inc  = (i_state.lost_count != COUNT_MAX) ?
                       i_state.lost_count + 8'd1 : i_state.lost_count;

    always_comb begin
        ns              = i_state;
        res.node_status = ST_RUNNING;
        res.outcome     = OC_RUNNING;
        res.error_code  = ERR_NONE;
        res.send_cmd    = 1'b0;
        res.cmd_code    = 8'd0;
        res.phase_now   = PHN_DONE;

        unique case (i_item.mode)
            MODE_START: begin
                ns                = STATE_RESET;
                ns.direction_down = i_item.go_down;
                ns.phase          = PH_PREP;
                res.send_cmd      = 1'b1;
                res.cmd_code      = start_ids[15:8];
            end
            MODE_RESPONSE: begin
                if (i_state.phase == PH_PREP && !i_state.resp_seen) begin
                    ns.accepted_flag = i_item.resp_accepted;
                    ns.resp_seq      = seq_tag;
                    ns.resp_seen     = 1'b1;
                    if (i_state.latest_done_seq == seq_tag) begin
                        ns.done_seen = 1'b1;
                    end
                end
            end
            MODE_FEEDBACK: begin
                if (i_state.phase != PH_DONE && i_item.feedback_code == cur_ids[7:0]) begin
                    ns.latest_done_seq = seq_tag;
                    if (i_state.resp_seq == seq_tag) begin
                        ns.done_seen = 1'b1;
                    end
                end
            end
            MODE_TICK: begin
                if (i_state.phase == PH_DONE) begin
                    res.node_status = ST_SUCCESS;
                end else if (i_state.phase == PH_PREP) begin
                    ns.elapsed_ticks = el_inc;
                    priority if (!i_state.resp_seen && late) begin
                        ns.phase       = PH_DONE;
                        res.node_status = ST_FAILURE;
                        res.outcome    = OC_FAILED;
                        res.error_code = ERR_ACK_TIMEOUT;
                    end else if (!i_state.resp_seen) begin
                        // keep waiting for the response
                    end else if (!i_state.accepted_flag) begin
                        ns.phase       = PH_DONE;
                        res.node_status = ST_FAILURE;
                        res.outcome    = OC_FAILED;
                        res.error_code = ERR_REJECTED;
                    end else if (i_state.done_seen && !i_item.vision_start_ok) begin
                        ns.phase       = PH_DONE;
                        res.node_status = ST_FAILURE;
                        res.outcome    = OC_FAILED;
                        res.error_code = ERR_VISION_FAIL;
                    end else if (i_state.done_seen) begin
                        ns.phase         = PH_DETECT;
                        ns.elapsed_ticks = 24'd0;
                        ns.seen_count    = 8'd0;
                        ns.lost_count    = 8'd0;
                    end else if (late) begin
                        ns.phase       = PH_DONE;
                        res.node_status = ST_FAILURE;
                        res.outcome    = OC_FAILED;
                        res.error_code = ERR_DONE_TIMEOUT;
                    end else begin
                        // keep waiting for the done feedback
                    end
                end else begin
                    ns.elapsed_ticks = el_inc;
                    if (el_inc >= min_one24(i_cfg.wait_timeout_ticks)) begin
                        ns.phase       = PH_DONE;
                        res.node_status = ST_FAILURE;
                        res.outcome    = OC_FAILED;
                        res.error_code = ERR_WAIT_TIMEOUT;
                    end else begin
                        if (fresh) begin
                            ns.last_frame_seq = i_item.obs_frame_seq;
                        end
                        if (blk) begin
                            if (fresh) begin
                                ns.seen_count = seen_sat;
                                ns.lost_count = 8'd0;
                                if (seen_sat >= sf) begin
                                    ns.ever_seen = 1'b1;
                                    ns.phase     = PH_GONE;
                                end
                            end
                        end else if (fresh) begin
                            ns.seen_count = 8'd0;
                            ns.lost_count = lost_inc;
                            if (!i_state.ever_seen) begin
                                if (el_inc >= min_one24(i_cfg.detect_timeout_ticks) ||
                                    (i_item.sensor_ready && lost_inc >= lf)) begin
                                    ns.phase        = PH_DONE;
                                    res.node_status = ST_SUCCESS;
                                    res.outcome     = OC_NO_TARGET;
                                end
                            end else if (lost_inc >= lf) begin
                                ns.phase        = PH_DONE;
                                res.node_status = ST_SUCCESS;
                                res.outcome     = OC_TARGET_GONE;
                            end
                        end
                    end
                end
            end
            default: begin
            end
        endcase

        res.phase_now = phase_code(ns.phase);
    end

    assign o_state  = ns;
    assign o_result = res;

endmodule

FILE: hw/rtl/ows_outq.sv
// Result register with one skid entry for the obstacle wait sequencer.
// Depends on ows_pkg for the result item type.
module ows_outq
    import ows_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_out i_data,
    input  logic i_out_stall,
    output logic o_valid,
    output t_out o_data,
    output logic o_full
);

    logic r_main_valid;
    logic r_skid_valid;
    t_out r_main;
    t_out r_skid;
    logic pop;

    assign pop = r_main_valid && !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_main_valid || pop) begin
            if (r_skid_valid) begin
                // push is held off while the skid entry is full
                r_main_valid <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_main_valid <= i_push;
            end
        end else if (i_push) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_main_valid || pop) begin
            r_main <= r_skid_valid ? r_skid : i_data;
        end else if (i_push) begin
            r_skid <= i_data;
        end
    end

    assign o_valid = r_main_valid;
    assign o_data  = r_main;
    assign o_full  = r_skid_valid;

endmodule

FILE: hw/rtl/obstacle_wait_sequencer.sv
// Obstacle wait sequencer top level: configuration registers, run state, core and
// result queue. Depends on ows_pkg, ows_core and ows_outq.
//
// Usage:
//  Input channel i_in_valid / o_in_stall / i_in_item carries start, tick, command
//  response and feedback items. Each accepted item yields exactly one result item on
//  o_out_valid / i_out_stall / o_out_item, in order.
//  The state and result are registered at the accept edge, the result via the skid
//  entry when the result register is occupied. One item per cycle while o_in_stall is
//  low; a single pass of compare and counter logic (ows_core) updates the run state.
//  The result register has a one-entry skid behind it, so an item is still taken
//  while a result waits; o_in_stall rises only when both entries hold results and
//  falls the cycle after the receiver takes one.
//  Configuration is written through i_cfg_we / i_cfg_idx / i_cfg_data, by the user
//  only while idle (not enforced by the block); unknown indexes are ignored.
//  Reset (synchronous, active low) loads the default configuration, returns the
//  sequencer to the done phase with cleared counters and empties the result queue.
module obstacle_wait_sequencer
    import ows_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in                   i_in_item,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out                  o_out_item,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg   r_cfg;
    t_state r_state;
    t_state n_state;
    t_out   step_result;
    logic   accept;
    logic   q_full;

    assign accept     = i_in_valid && !q_full;
    assign o_in_stall = q_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SEEN_FRAMES: r_cfg.seen_frames           <= i_cfg_data[7:0];
                CFG_LOST_FRAMES: r_cfg.lost_frames           <= i_cfg_data[7:0];
                CFG_DETECT_TO:   r_cfg.detect_timeout_ticks  <= i_cfg_data[23:0];
                CFG_WAIT_TO:     r_cfg.wait_timeout_ticks    <= i_cfg_data[23:0];
                CFG_COMMAND_TO:  r_cfg.command_timeout_ticks <= i_cfg_data[23:0];
                CFG_RAISE_IDS:   r_cfg.raise_ids             <= i_cfg_data[15:0];
                CFG_LOWER_IDS:   r_cfg.lower_ids             <= i_cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

    ows_core u_core (
        .i_item   (i_in_item),
        .i_state  (r_state),
        .i_cfg    (r_cfg),
        .o_state  (n_state),
        .o_result (step_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= STATE_RESET;
        end else if (accept) begin
            r_state <= n_state;
        end
    end

    ows_outq u_outq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (accept),
        .i_data      (step_result),
        .i_out_stall (i_out_stall),
        .o_valid     (o_out_valid),
        .o_data      (o_out_item),
        .o_full      (q_full)
    );

    // a full skid entry implies a result is on show
    a_stall_has_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid)
        else $error("input stalled with no result on the output");

    a_accept_shows_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_out_valid)
        else $error("accepted item produced no result");

    a_cmd_in_prep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.send_cmd) |->
        (o_out_item.phase_now == PHN_PREP && o_out_item.node_status == ST_RUNNING))
        else $error("command pulse outside the prep phase");

    a_finish_is_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.node_status != ST_RUNNING) |->
        (o_out_item.phase_now == PHN_DONE))
        else $error("finished result with an active phase");

endmodule
